>>> rtl/slope_intercept_line_point_assert.svh
// Assertion macros for the slope-intercept line point block.
// Used by rtl/slope_intercept_line_point.sv; expects clk and rst_n in scope.
`ifndef SLOPE_INTERCEPT_LINE_POINT_ASSERT_SVH
`define SLOPE_INTERCEPT_LINE_POINT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every clock edge outside reset.
`define SLP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slope_intercept_line_point: assertion failed");

// Checks that a condition implies another one in the following cycle.
`define SLP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("slope_intercept_line_point: assertion failed");

`else

`define SLP_ASSERT(label, prop)
`define SLP_ASSERT_NEXT(label, pre, post)

`endif

`endif

>>> rtl/slp_pkg.sv
// Package for the slope-intercept line point block: coordinate width and
// the packed command and result types. Depends on nothing.
package slp_pkg;

    // Width of every pixel coordinate and of the step index.
    parameter int COORD_BITS = 10;

    typedef logic [COORD_BITS-1:0] coord_t;

    // One query: two endpoints and a step along the major axis.
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t step_index;
    } cmd_t;

    // One answer: the selected pixel and the span flags.
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   is_last;
        logic   beyond_span;
    } result_t;

endpackage

>>> rtl/slope_intercept_line_point.sv
// Slope-intercept line point: a fully pipelined line pixel generator.
// Depends on rtl/slp_pkg.sv and rtl/slope_intercept_line_point_assert.svh.
//
// Each transaction presents two endpoints and a step index on cmd with start
// high; busy is always low, so a new transaction may be issued on every clock.
// The answer appears on result with done high for exactly one cycle,
// in the order the transactions were issued. The result passes through
// four stages of delta, multiply and numerator work, then the exact
// rounding division, which resolves one quotient bit per pipeline stage,
// and then one output register. The receiver must take each result in
// the cycle it is shown.
module slope_intercept_line_point (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  slp_pkg::cmd_t   cmd,
    output logic            done,
    output slp_pkg::result_t result
);

`include "slope_intercept_line_point_assert.svh"

    localparam int W       = slp_pkg::COORD_BITS;
    localparam int DW      = W + 1;        // signed delta width
    localparam int PW      = 2 * DW;       // signed product width
    localparam int NW      = 2 * W + 4;    // numerator working width
    localparam int RW      = 2 * W + 1;    // dividend and remainder width
    localparam int Latency = W + 5;

    // Values that travel alongside the arithmetic.
    typedef struct packed {
        logic           x_major;
        slp_pkg::coord_t major_coord;
        logic           is_last;
        logic           beyond;
    } side_t;

    // The block never holds off a transaction.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: endpoint deltas and their magnitudes.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] dx_c, dy_c, ndx_c, ndy_c;
    logic [W-1:0]         adx_c, ady_c;

    always_comb
    begin
        dx_c  = $signed({1'b0, cmd.bx}) - $signed({1'b0, cmd.ax});
        dy_c  = $signed({1'b0, cmd.by}) - $signed({1'b0, cmd.ay});
        ndx_c = -dx_c;
        ndy_c = -dy_c;
        adx_c = dx_c[DW-1] ? ndx_c[W-1:0] : dx_c[W-1:0];
        ady_c = dy_c[DW-1] ? ndy_c[W-1:0] : dy_c[W-1:0];
    end

    logic                 s1_valid_reg;
    slp_pkg::cmd_t        s1_cmd_reg;
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg;
    logic [W-1:0]         s1_adx_reg, s1_ady_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd;
        s1_dx_reg  <= dx_c;
        s1_dy_reg  <= dy_c;
        s1_adx_reg <= adx_c;
        s1_ady_reg <= ady_c;
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the major axis, span flags, major coordinate, and the
    // operands of the rounding equation with the divisor made positive.
    // ------------------------------------------------------------------
    logic                 x_major_c;
    slp_pkg::coord_t      maj_a_c, maj_b_c, min_a_c, span_c, maj_lo_c, step_c;
    logic signed [DW-1:0] dmaj_c, dmin_c, ndmin_c, off_c, dm_c;
    logic [W-1:0]         d_c;
    side_t                side2_c;

    always_comb
    begin
        x_major_c = s1_adx_reg >= s1_ady_reg;
        step_c    = s1_cmd_reg.step_index;
        if (x_major_c)
        begin
            maj_a_c = s1_cmd_reg.ax;
            maj_b_c = s1_cmd_reg.bx;
            min_a_c = s1_cmd_reg.ay;
            dmaj_c  = s1_dx_reg;
            dmin_c  = s1_dy_reg;
            span_c  = s1_adx_reg;
        end
        else
        begin
            maj_a_c = s1_cmd_reg.ay;
            maj_b_c = s1_cmd_reg.by;
            min_a_c = s1_cmd_reg.ax;
            dmaj_c  = s1_dy_reg;
            dmin_c  = s1_dx_reg;
            span_c  = s1_ady_reg;
        end

        maj_lo_c = (maj_a_c <= maj_b_c) ? maj_a_c : maj_b_c;

        // Offset of this step from the first endpoint along the major axis.
        if (maj_a_c <= maj_b_c)
        begin
            off_c = $signed({1'b0, step_c});
        end
        else
        begin
            off_c = $signed({1'b0, step_c}) - $signed({1'b0, span_c});
        end

        // A single point uses a unit divisor with no slope, giving the
        // endpoint's own minor coordinate.
        ndmin_c = -dmin_c;
        if (span_c == '0)
        begin
            d_c  = W'(1);
            dm_c = '0;
        end
        else
        begin
            d_c  = span_c;
            dm_c = dmaj_c[DW-1] ? ndmin_c : dmin_c;
        end

        side2_c.x_major     = x_major_c;
        side2_c.major_coord = maj_lo_c + step_c;
        side2_c.is_last     = step_c == span_c;
        side2_c.beyond      = step_c > span_c;
    end

    logic                 s2_valid_reg;
    side_t                s2_side_reg;
    logic [W-1:0]         s2_ma_reg, s2_d_reg;
    logic signed [DW-1:0] s2_dm_reg, s2_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= side2_c;
        s2_ma_reg   <= min_a_c;
        s2_d_reg    <= d_c;
        s2_dm_reg   <= dm_c;
        s2_off_reg  <= off_c;
    end

    // ------------------------------------------------------------------
    // Stage 3: the two products of the numerator.
    // ------------------------------------------------------------------
    logic                 s3_valid_reg;
    side_t                s3_side_reg;
    logic [2*W-1:0]       s3_pmd_reg;
    logic signed [PW-1:0] s3_pmo_reg;
    logic [W-1:0]         s3_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg <= s2_side_reg;
        s3_pmd_reg  <= {{W{1'b0}}, s2_ma_reg} * {{W{1'b0}}, s2_d_reg};
        s3_pmo_reg  <= PW'(s2_dm_reg) * PW'(s2_off_reg);
        s3_d_reg    <= s2_d_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: numerator 2*ma*d + 2*dm*off + d, floored at zero, and the
    // divisor 2*d; these load the head of the divider.
    // ------------------------------------------------------------------
    logic [NW-1:0] num_c;
    logic [RW-1:0] rem0_c;

    always_comb
    begin
        num_c  = (NW'(s3_pmd_reg) << 1) + (NW'(s3_pmo_reg) << 1) + NW'(s3_d_reg);
        rem0_c = num_c[NW-1] ? '0 : num_c[RW-1:0];
    end

    logic          div_valid_reg [0:W];
    side_t         div_side_reg  [0:W];
    logic [RW-1:0] rem_reg       [0:W];
    logic [W:0]    dv_reg        [0:W];
    logic [W-1:0]  q_reg         [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg[0] <= 1'b0;
        end
        else
        begin
            div_valid_reg[0] <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_side_reg[0] <= s3_side_reg;
        rem_reg[0]      <= rem0_c;
        dv_reg[0]       <= {s3_d_reg, 1'b0};
        q_reg[0]        <= '0;
    end

    // ------------------------------------------------------------------
    // Divider: restoring division, one quotient bit per stage, most
    // significant bit first. The quotient is known to fit in W bits.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic [RW-1:0] sh_c;
        logic          ge_c;
        logic [RW-1:0] rem_next;
        logic [W-1:0]  q_next;

        always_comb
        begin
            sh_c     = {{(RW-W-1){1'b0}}, dv_reg[k]} << (W - 1 - k);
            ge_c     = rem_reg[k] >= sh_c;
            rem_next = ge_c ? (rem_reg[k] - sh_c) : rem_reg[k];
            q_next   = q_reg[k];
            q_next[W-1-k] = ge_c;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            div_side_reg[k+1] <= div_side_reg[k];
            rem_reg[k+1]      <= rem_next;
            dv_reg[k+1]       <= dv_reg[k];
            q_reg[k+1]        <= q_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: place the major and minor coordinates, and for a step
    // past the span zero the coordinates and is_last and set beyond_span.
    // ------------------------------------------------------------------
    slp_pkg::result_t res_next;
    logic             done_reg;
    slp_pkg::result_t result_reg;

    always_comb
    begin
        if (div_side_reg[W].beyond)
        begin
            res_next.pixel_x     = '0;
            res_next.pixel_y     = '0;
            res_next.is_last     = 1'b0;
            res_next.beyond_span = 1'b1;
        end
        else
        begin
            res_next.pixel_x     = div_side_reg[W].x_major ?
                                   div_side_reg[W].major_coord : q_reg[W];
            res_next.pixel_y     = div_side_reg[W].x_major ?
                                   q_reg[W] : div_side_reg[W].major_coord;
            res_next.is_last     = div_side_reg[W].is_last;
            res_next.beyond_span = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `SLP_ASSERT(a_fixed_latency, start |-> ##Latency done)
    `SLP_ASSERT(a_beyond_zero, (done && result.beyond_span) |-> (result.pixel_x == '0 && result.pixel_y == '0 && !result.is_last))
    `SLP_ASSERT(a_last_in_span, (done && result.is_last) |-> !result.beyond_span)
    `SLP_ASSERT(a_divisor_nonzero, div_valid_reg[0] |-> (dv_reg[0] != '0))
    `SLP_ASSERT_NEXT(a_valid_enters, s3_valid_reg, div_valid_reg[0])

endmodule
